// ===== hdl/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Segregated free-list allocator package
// Shared constants, result status codes and request kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfla_pkg;

  // Default geometry of the arena and size classes.
  localparam int unsigned ARENA_BYTES_DEF     = 65536;
  localparam int unsigned ALIGN_BYTES_DEF     = 8;
  localparam int unsigned MAX_SMALL_BYTES_DEF = 128;

  // Refill register: reset value and the largest count honored.
  localparam logic [5:0] REFILL_RESET = 6'd20;
  localparam logic [5:0] REFILL_MAX   = 6'd32;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_RELEASED  = 2'd1;
  localparam logic [1:0] ST_LARGE     = 2'd2;
  localparam logic [1:0] ST_NO_MEMORY = 2'd3;

endpackage

// ===== hdl/segregated_free_list_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Segregated free-list pool allocator
// Small-block allocator over a bump arena with one free list per size class.
// ----------------------------------------------------------------------------
// Usage: a request transaction (in_kind, in_size_bytes, in_block_address) is
// taken when in_valid is high and in_stall is low. Every request yields
// exactly one result transaction (out_granted_address, out_status), taken
// when out_valid is high and out_stall is low. refill_count is to be written
// over the APB-style port while the block is idle; the block does not enforce it.
// Sequence: a release or an oversized request goes straight to the handover
// state; a pop from a non-empty list first reads the head's link. A refill
// checks the pool, chains each carved block beyond the first (link writes
// through the single write port of the link memory), runs a repeated
// subtraction when the pool only partly covers the refill, and scans the
// classes and borrows a free block when the arena runs dry.
// One request is handled at a time; in_stall is high from acceptance until
// the result is loaded into the output register.
// Reset clears the list heads to empty, the pool and arena pointers to zero
// and refill_count to 20; the link memory is not cleared.
// A stalled result waits in the output register; the next request may be
// taken meanwhile, and its result waits until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segregated_free_list_pool_allocator_unit
  import sfla_pkg::*;
#(
  parameter int unsigned ARENA_BYTES     = ARENA_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES     = ALIGN_BYTES_DEF,
  parameter int unsigned MAX_SMALL_BYTES = MAX_SMALL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_size_bytes,
  input  logic [15:0] in_block_address,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_granted_address,
  output logic [1:0]  out_status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NC    = MAX_SMALL_BYTES / ALIGN_BYTES;
  localparam int unsigned CW    = $clog2(NC);
  localparam int unsigned ASH   = $clog2(ALIGN_BYTES);
  localparam int unsigned DEPTH = ARENA_BYTES / ALIGN_BYTES;
  localparam int unsigned LW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned SW    = $clog2(MAX_SMALL_BYTES) + 1;
  localparam int unsigned TW    = SW + 6;
  localparam int unsigned GW    =
    $clog2(ARENA_BYTES + 2 * MAX_SMALL_BYTES * 32) + 2;
  localparam logic [PW-1:0] LINK_NULL = {1'b1, {(PW-1){1'b0}}};
  localparam logic [GW-1:0] ARENA_G   = GW'(ARENA_BYTES);
  localparam logic [16:0]   MAX_S     = 17'(MAX_SMALL_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_CHK, S_DIV, S_SCAN, S_BORROW, S_LINKS, S_DONE
  } state_t;

  state_t         state_r, state_nxt;
  logic [PW-1:0]  heads_r [NC];
  logic [PW-1:0]  heads_nxt [NC];
  logic [PW-1:0]  pstart_r, pstart_nxt;
  logic [PW-1:0]  pend_r, pend_nxt;
  logic [PW-1:0]  grown_r, grown_nxt;
  logic [PW-1:0]  atop_r, atop_nxt;
  logic [5:0]     refill_r;
  logic [CW-1:0]  cls_r, cls_nxt;
  logic [CW-1:0]  scls_r, scls_nxt;
  logic [SW-1:0]  bsz_r, bsz_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [5:0]     q_r, q_nxt;
  logic [5:0]     idx_r, idx_nxt;
  logic [PW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  ptr_r, ptr_nxt;
  logic [PW-1:0]  cur_r, cur_nxt;
  logic [PW-1:0]  res_addr_r, res_addr_nxt;
  logic [1:0]     res_st_r, res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_addr_r, out_addr_nxt;
  logic [1:0]     out_st_r, out_st_nxt;

  // Link memory ports.
  logic           lk_we;
  logic [LW-1:0]  lk_waddr, lk_raddr;
  logic [PW-1:0]  lk_wdata, lk_rdata;

  // Request decode.
  logic [16:0]    in_sz;
  logic [16:0]    in_cls_w;
  logic [CW-1:0]  in_cls;
  logic [16:0]    rel_full;
  logic           rel_ok;
  logic [PW-1:0]  rel_addr;
  logic [5:0]     cnt_clamped;

  // Shared carve arithmetic.
  logic [PW-1:0]  left;
  logic [TW-1:0]  total;
  logic [GW-1:0]  left_g, total_g, get_g, grown_g;
  logic [PW-1:0]  ptr_sel;
  logic [CW-1:0]  left_cls;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {26'd0, refill_r};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_r <= REFILL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      refill_r <= pwdata[5:0];
    end
  end

  // Size rounding and class of the incoming request.
  always_comb begin
    in_sz    = (in_size_bytes == 16'd0) ? 17'd1 : {1'b0, in_size_bytes};
    in_cls_w = ((in_sz + 17'(ALIGN_BYTES - 1)) >> ASH) - 17'd1;
    in_cls   = in_cls_w[CW-1:0];
    // Released address rounded down to the alignment; outside the arena it is dropped.
    rel_full = {1'b0, in_block_address[15:ASH], {ASH{1'b0}}};
    rel_ok   = (32'(rel_full) < 32'(ARENA_BYTES));
    rel_addr = PW'(rel_full);
    if (refill_r == 6'd0) begin
      cnt_clamped = 6'd1;
    end else if (refill_r > REFILL_MAX) begin
      cnt_clamped = REFILL_MAX;
    end else begin
      cnt_clamped = refill_r;
    end
  end

  // Pool remainder, refill size and arena growth request.
  always_comb begin
    logic [PW-1:0] left_up;
    left     = (pend_r >= pstart_r) ? (pend_r - pstart_r) : '0;
    total    = TW'(bsz_r) * TW'(cnt_r);
    left_g   = GW'(left);
    total_g  = GW'(total);
    grown_g  = GW'(grown_r >> 4);
    grown_g  = ((grown_g + GW'(ALIGN_BYTES - 1)) >> ASH) << ASH;
    get_g    = (total_g << 1) + grown_g;
    left_up  = (left + PW'(ALIGN_BYTES - 1)) >> ASH;
    left_cls = CW'(left_up - PW'(1));
    ptr_sel  = heads_r[scls_r];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    heads_nxt     = heads_r;
    pstart_nxt    = pstart_r;
    pend_nxt      = pend_r;
    grown_nxt     = grown_r;
    atop_nxt      = atop_r;
    cls_nxt       = cls_r;
    scls_nxt      = scls_r;
    bsz_nxt       = bsz_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    cur_nxt       = cur_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    lk_we         = 1'b0;
    lk_waddr      = '0;
    lk_wdata      = '0;
    lk_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt = '0;
          cls_nxt      = in_cls;
          bsz_nxt      = SW'((in_cls_w + 17'd1) << ASH);
          cnt_nxt      = cnt_clamped;
          state_nxt    = S_DONE;
          if (in_sz > MAX_S) begin
            res_st_nxt = ST_LARGE;
          end else if (in_kind == KIND_FREE) begin
            // Release pushes the block onto its class list.
            res_st_nxt = ST_RELEASED;
            if (rel_ok) begin
              lk_we             = 1'b1;
              lk_waddr          = rel_addr[ASH +: LW];
              lk_wdata          = heads_r[in_cls];
              heads_nxt[in_cls] = rel_addr;
            end
          end else if (!heads_r[in_cls][PW-1]) begin
            // Non-empty list: fetch the head's link.
            ptr_nxt   = heads_r[in_cls];
            lk_raddr  = heads_r[in_cls][ASH +: LW];
            state_nxt = S_POP;
          end else begin
            scls_nxt  = in_cls;
            state_nxt = S_CHK;
          end
        end
      end

      S_POP: begin
        heads_nxt[cls_r] = lk_rdata;
        res_addr_nxt     = ptr_r;
        res_st_nxt       = ST_ALLOCATED;
        state_nxt        = S_DONE;
      end

      S_CHK: begin
        if (left_g >= total_g) begin
          // Pool covers the whole refill.
          res_addr_nxt = pstart_r;
          res_st_nxt   = ST_ALLOCATED;
          pstart_nxt   = pstart_r + PW'(total);
          cur_nxt      = pstart_r + PW'(bsz_r);
          idx_nxt      = 6'd1;
          if (cnt_r > 6'd1) begin
            heads_nxt[cls_r] = pstart_r + PW'(bsz_r);
            state_nxt        = S_LINKS;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (left >= PW'(bsz_r)) begin
          // Partial cover: count how many blocks fit.
          rem_nxt   = left;
          q_nxt     = 6'd0;
          state_nxt = S_DIV;
        end else begin
          // Leftover piece goes to its own class list.
          if (left != '0) begin
            lk_we               = !pstart_r[PW-1];
            lk_waddr            = pstart_r[ASH +: LW];
            lk_wdata            = heads_r[left_cls];
            heads_nxt[left_cls] = pstart_r;
          end
          if (GW'(atop_r) <= ARENA_G && get_g <= ARENA_G - GW'(atop_r)) begin
            pstart_nxt = atop_r;
            atop_nxt   = atop_r + PW'(get_g);
            grown_nxt  = grown_r + PW'(get_g);
            pend_nxt   = atop_r + PW'(get_g);
          end else begin
            scls_nxt  = cls_r;
            state_nxt = S_SCAN;
          end
        end
      end

      S_DIV: begin
        if (rem_r >= PW'(bsz_r)) begin
          rem_nxt = rem_r - PW'(bsz_r);
          q_nxt   = q_r + 6'd1;
        end else begin
          cnt_nxt   = q_r;
          state_nxt = S_CHK;
        end
      end

      S_SCAN: begin
        // Look for a block to borrow in this or a larger class.
        if (!ptr_sel[PW-1]) begin
          ptr_nxt   = ptr_sel;
          lk_raddr  = ptr_sel[ASH +: LW];
          state_nxt = S_BORROW;
        end else if (scls_r == CW'(NC - 1)) begin
          pstart_nxt   = '0;
          pend_nxt     = '0;
          res_addr_nxt = '0;
          res_st_nxt   = ST_NO_MEMORY;
          state_nxt    = S_DONE;
        end else begin
          scls_nxt = scls_r + CW'(1);
        end
      end

      S_BORROW: begin
        heads_nxt[scls_r] = lk_rdata;
        pstart_nxt        = ptr_r;
        pend_nxt          = ptr_r + (PW'(scls_r) + PW'(1) << ASH);
        state_nxt         = S_CHK;
      end

      S_LINKS: begin
        // Chain the carved blocks, one link per cycle.
        lk_we    = !cur_r[PW-1];
        lk_waddr = cur_r[ASH +: LW];
        lk_wdata = (idx_r + 6'd1 == cnt_r) ? LINK_NULL : cur_r + PW'(bsz_r);
        cur_nxt  = cur_r + PW'(bsz_r);
        idx_nxt  = idx_r + 6'd1;
        if (idx_r + 6'd1 == cnt_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r[15:0];
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, allocator bookkeeping and output register.
  always_ff @(posedge clk) begin
    cls_r      <= cls_nxt;
    scls_r     <= scls_nxt;
    bsz_r      <= bsz_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    ptr_r      <= ptr_nxt;
    cur_r      <= cur_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pstart_r    <= '0;
      pend_r      <= '0;
      grown_r     <= '0;
      atop_r      <= '0;
      for (int i = 0; i < NC; i++) begin
        heads_r[i] <= LINK_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pstart_r    <= pstart_nxt;
      pend_r      <= pend_nxt;
      grown_r     <= grown_nxt;
      atop_r      <= atop_nxt;
      heads_r     <= heads_nxt;
    end
  end

  sfla_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

  // A new result only appears when a finished request is handed over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished request");

  // Carving never runs past the pool end.
  a_pool_order: assert property (@(posedge clk) disable iff (!rst_n)
    pstart_r <= pend_r)
    else $error("pool start passed pool end");

  // The bump pointer stays inside the arena.
  a_arena_bound: assert property (@(posedge clk) disable iff (!rst_n)
    GW'(atop_r) <= ARENA_G)
    else $error("arena top beyond arena");

  // Only a successful allocation carries an address.
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ALLOCATED) |-> (out_granted_address == 16'd0))
    else $error("non-zero address on a failed or release result");

endmodule

// ===== hdl/sfla_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfla_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/segregated_free_list_pool_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool allocator testbench
// Drives allocate and release transactions into the allocator, mirrors the
// free lists, pool and arena in a behavioral predictor, and checks every
// result transaction in order. The refill count is reprogrammed between
// phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module segregated_free_list_pool_allocator_unit_tb
  import sfla_pkg::*;
;

  localparam int unsigned ARENA      = ARENA_BYTES_DEF;
  localparam int unsigned ALIGN      = ALIGN_BYTES_DEF;
  localparam int unsigned MAX_SMALL  = MAX_SMALL_BYTES_DEF;
  localparam int unsigned N_CLASSES  = MAX_SMALL / ALIGN;
  localparam int unsigned N_LINKS    = ARENA / ALIGN;
  localparam int unsigned NULL_LINK  = 32'h8000_0000;
  localparam logic [2:0]  REFILL_REG_ADDR = 3'd0;
  localparam int          IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [15:0] granted;
    logic [1:0]  status;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [15:0] in_size_bytes;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_granted_address;
  logic [1:0]  out_status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segregated_free_list_pool_allocator_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_size_bytes       (in_size_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Mirror of the allocator state.
  int unsigned   refill_setting;
  int unsigned   class_heads [N_CLASSES];
  int unsigned   link_mem [N_LINKS];
  int unsigned   pool_lo;
  int unsigned   pool_hi;
  int unsigned   grown_bytes;
  int unsigned   arena_next;

  alloc_result_t pending_results[$];
  logic [15:0]   live_addr[$];
  logic [15:0]   live_size[$];
  int            error_count;
  bit            offering;
  bit            quiet;
  bit            long_hold_req;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned round_to_align(int unsigned b);
    return ((b + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic int unsigned size_class(int unsigned b);
    return (b + ALIGN - 1) / ALIGN - 1;
  endfunction

  function automatic int unsigned read_link(int unsigned a);
    return (a / ALIGN < N_LINKS) ? link_mem[a / ALIGN] : NULL_LINK;
  endfunction

  function automatic void push_free(int unsigned cls, int unsigned a);
    if (cls >= N_CLASSES) return;
    if (a / ALIGN < N_LINKS) link_mem[a / ALIGN] = class_heads[cls];
    class_heads[cls] = a;
  endfunction

  // Carve blocks out of the pool, growing it from the arena or borrowing a
  // same-size or larger free block when it runs short.
  function automatic bit carve_pool(input int unsigned bsz, inout int unsigned cnt,
                                    output int unsigned first);
    int unsigned left;
    int unsigned total;
    int unsigned fetch;
    int unsigned sz;
    int unsigned cls;
    int unsigned p;
    bit          found;
    first = 0;
    forever begin
      left  = (pool_hi >= pool_lo) ? pool_hi - pool_lo : 0;
      total = bsz * cnt;
      if (left >= total) begin
        first = pool_lo;
        pool_lo += total;
        return 1'b1;
      end
      if (left >= bsz) begin
        cnt = left / bsz;
        first = pool_lo;
        pool_lo += bsz * cnt;
        return 1'b1;
      end
      fetch = 2 * total + round_to_align(grown_bytes >> 4);
      found = 1'b0;
      if (left > 0) push_free(size_class(left), pool_lo);
      if (arena_next <= ARENA && fetch <= ARENA - arena_next) begin
        pool_lo = arena_next;
        arena_next += fetch;
        grown_bytes += fetch;
        pool_hi = pool_lo + fetch;
        continue;
      end
      for (sz = bsz; sz <= MAX_SMALL && !found; sz += ALIGN) begin
        cls = size_class(sz);
        p = class_heads[cls];
        if ((p & NULL_LINK) == 0) begin
          class_heads[cls] = read_link(p);
          pool_lo = p;
          pool_hi = p + sz;
          found = 1'b1;
        end
      end
      if (!found) begin
        pool_lo = 0;
        pool_hi = 0;
        return 1'b0;
      end
    end
  endfunction

  // Expected result of one request; updates the mirrored state.
  function automatic alloc_result_t predict_request(logic kind, logic [15:0] size_in,
                                                    logic [15:0] addr_in);
    alloc_result_t res;
    int unsigned   sz;
    int unsigned   cls;
    int unsigned   head;
    int unsigned   bsz;
    int unsigned   cnt;
    int unsigned   first;
    int unsigned   cur;
    sz = (size_in == 0) ? 1 : size_in;
    res.granted = '0;
    if (sz > MAX_SMALL) begin
      res.status = ST_LARGE;
    end else if (kind == KIND_FREE) begin
      if ((addr_in / ALIGN) * ALIGN < ARENA) push_free(size_class(sz), (addr_in / ALIGN) * ALIGN);
      res.status = ST_RELEASED;
    end else begin
      cls = size_class(sz);
      head = class_heads[cls];
      if ((head & NULL_LINK) == 0) begin
        class_heads[cls] = read_link(head);
        res.granted = head[15:0];
        res.status = ST_ALLOCATED;
      end else begin
        bsz = round_to_align(sz);
        cnt = (refill_setting == 0) ? 1 : (refill_setting > REFILL_MAX) ? REFILL_MAX
                                                                       : refill_setting;
        if (carve_pool(bsz, cnt, first)) begin
          if (cnt > 1) begin
            class_heads[cls] = first + bsz;
            for (int unsigned i = 1; i < cnt; i++) begin
              cur = first + i * bsz;
              if (cur / ALIGN < N_LINKS) link_mem[cur / ALIGN] = (i + 1 == cnt) ? NULL_LINK
                                                                                : cur + bsz;
            end
          end
          res.granted = first[15:0];
          res.status = ST_ALLOCATED;
        end else begin
          res.status = ST_NO_MEMORY;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request transaction and wait until it is taken.
  task automatic send_request(logic kind, logic [15:0] size_in, logic [15:0] addr_in);
    int            gap;
    alloc_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_size_bytes    <= size_in;
    in_block_address <= addr_in;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    res = predict_request(kind, size_in, addr_in);
    pending_results.push_back(res);
    if (kind == KIND_ALLOC && res.status == ST_ALLOCATED && live_addr.size() < 400) begin
      live_addr.push_back(res.granted);
      live_size.push_back(size_in);
    end
  endtask

  task automatic stop_offering();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic wait_all_results();
    stop_offering();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Program the refill count once the allocator has gone idle.
  task automatic write_refill(logic [31:0] value);
    wait_all_results();
    repeat (200) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REFILL_REG_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    refill_setting = value & 32'h3F;
  endtask

  // One random transaction: mostly allocations and well-formed releases.
  task automatic send_random_request();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_request(KIND_ALLOC, 16'($urandom_range(1, MAX_SMALL)), 16'($urandom()));
    end else if (r < 54) begin
      send_request(KIND_ALLOC, 16'($urandom_range(MAX_SMALL + 1, 16'hFFFF)),
                   16'($urandom()));
    end else if (r < 92 && live_addr.size() != 0) begin
      idx = $urandom_range(0, live_addr.size() - 1);
      send_request(KIND_FREE, live_size[idx], live_addr[idx]);
      live_addr.delete(idx);
      live_size.delete(idx);
    end else begin
      send_request(KIND_FREE, 16'($urandom_range(0, 200)), 16'($urandom()));
    end
  endtask

  task automatic test_field_extremes();
    send_request(KIND_ALLOC, 16'd0, 16'hFFFF);
    send_request(KIND_ALLOC, 16'd1, 16'h0000);
    send_request(KIND_ALLOC, 16'd8, 16'h0000);
    send_request(KIND_ALLOC, 16'd9, 16'h0000);
    send_request(KIND_ALLOC, 16'd128, 16'h0000);
    send_request(KIND_ALLOC, 16'd129, 16'h0000);
    send_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(KIND_FREE, 16'hFFFF, 16'h0010);
    // Zero-size release and an unaligned release.
    send_request(KIND_FREE, 16'd0, 16'h0000);
    send_request(KIND_FREE, 16'd16, 16'h0107);
    // Foreign release at the top of the arena, then a double release.
    send_request(KIND_FREE, 16'd128, 16'hFFFF);
    send_request(KIND_FREE, 16'd128, 16'hFFF8);
    send_request(KIND_FREE, 16'd128, 16'hFFF8);
    send_request(KIND_ALLOC, 16'd128, 16'h0000);
    send_request(KIND_ALLOC, 16'd121, 16'h0000);
    send_request(KIND_ALLOC, 16'd1, 16'h5555);
    send_request(KIND_ALLOC, 16'd16, 16'hAAAA);
    wait_all_results();
  endtask

  task automatic test_refill_settings();
    logic [31:0] settings[7];
    settings = '{32'd1, 32'd32, 32'd0, 32'd63, 32'd5, 32'd20, 32'd0};
    settings[6] = $urandom_range(1, 32);
    foreach (settings[i]) begin
      write_refill(settings[i]);
      repeat (150) send_random_request();
    end
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (30) send_random_request();
    wait_all_results();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (100) send_random_request();
    quiet = 1'b0;
    wait_all_results();
  endtask

  task automatic test_random_mix();
    repeat (300) send_random_request();
    wait_all_results();
    repeat (200) send_random_request();
  endtask

  // Result side: random stall, with an occasional long hold-off on request.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 50);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Result checking and the inactivity watchdog.
  int idle_cycles = 0;
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_granted_address, 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_granted_address !== want.granted)
          report_mismatch("granted_address", out_granted_address, want.granted);
        if (out_status !== want.status)
          report_mismatch("status", {14'd0, out_status}, {14'd0, want.status});
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    error_count = 0;
    offering = 1'b0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    refill_setting = REFILL_RESET;
    foreach (class_heads[i]) class_heads[i] = NULL_LINK;
    foreach (link_mem[i]) link_mem[i] = 0;
    pool_lo = 0;
    pool_hi = 0;
    grown_bytes = 0;
    arena_next = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_ALLOC;
    in_size_bytes    <= '0;
    in_block_address <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= REFILL_REG_ADDR;
    pwdata           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_refill_settings();
    test_output_backpressure();
    test_back_to_back();
    test_random_mix();

    wait_all_results();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sfla_pkg.sv
hdl/sfla_ram.sv
hdl/segregated_free_list_pool_allocator_unit.sv
tb/segregated_free_list_pool_allocator_unit_tb.sv
